[rtl/emb_pkg.sv]
// Shared types and constants for the echo median bar-graph mapper.
`default_nettype none
package emb_pkg;

    localparam int DIV_W = 26;
    localparam int DEN_W = 9;
    localparam int ECHO_W = 15;
    localparam int DIST_W = 14;
    localparam int LIM_W = 9;

    localparam logic [ECHO_W-1:0] ECHO_TIMEOUT_US = 15'd30000;
    localparam logic [DEN_W-1:0] US_PER_CM = 9'd58;
    localparam logic [19:0] RECIP_58 = 20'd578525;
    localparam int RECIP_58_SH = 21;
    localparam logic [16:0] Q16_ONE = 17'd65536;
    localparam logic [16:0] Q16_HALF = 17'd32768;
    localparam logic [7:0] LEVEL_MAX = 8'd255;
    localparam logic [12:0] RECIP_100 = 13'd5243;
    localparam int RECIP_SH = 19;

    localparam logic REG_NEAR = 1'b0;
    localparam logic REG_FAR = 1'b1;

    typedef enum logic [7:0] {
        ST_IDLE  = 8'b0000_0001,
        ST_SCAN  = 8'b0000_0010,
        ST_DIST  = 8'b0000_0100,
        ST_RDIV  = 8'b0000_1000,
        ST_COLOR = 8'b0001_0000,
        ST_LIT1  = 8'b0010_0000,
        ST_LIT2  = 8'b0100_0000,
        ST_DONE  = 8'b1000_0000
    } emb_state_t;

    typedef struct packed {
        logic busy;
        logic done;
    } div_status_t;

endpackage
`default_nettype wire

[rtl/emb_div.sv]
// Restoring divider, one quotient bit per cycle.
`default_nettype none
module emb_div (
    input  wire logic                        aclk,
    input  wire logic                        aresetn,
    input  wire logic                        start,
    input  wire logic [emb_pkg::DIV_W-1:0]   dividend,
    input  wire logic [emb_pkg::DEN_W-1:0]   divisor,
    output logic [emb_pkg::DIV_W-1:0]        quotient,
    output emb_pkg::div_status_t             status
);

    localparam int CW = $clog2(emb_pkg::DIV_W);

    logic [emb_pkg::DEN_W-1:0] rem_reg, rem_next;
    logic [emb_pkg::DEN_W-1:0] den_reg;
    logic [emb_pkg::DIV_W-1:0] dq_reg, dq_next;
    logic [CW-1:0]             cnt_reg;
    logic                      busy_reg;
    logic                      done_reg;
    logic [emb_pkg::DEN_W:0]   shifted;
    logic [emb_pkg::DEN_W:0]   diff;
    logic                      fits;

    always_comb begin
        shifted = {rem_reg, dq_reg[emb_pkg::DIV_W-1]};
        diff = shifted - {1'b0, den_reg};
        fits = shifted >= {1'b0, den_reg};
        rem_next = fits ? diff[emb_pkg::DEN_W-1:0] : shifted[emb_pkg::DEN_W-1:0];
        dq_next = {dq_reg[emb_pkg::DIV_W-2:0], fits};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg <= '0;
        end else if (start) begin
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
            cnt_reg <= '0;
        end else if (busy_reg) begin
            cnt_reg <= cnt_reg + CW'(1);
            if (cnt_reg == CW'(emb_pkg::DIV_W - 1)) begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end else begin
            done_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            rem_reg <= '0;
            dq_reg <= dividend;
            den_reg <= divisor;
        end else if (busy_reg) begin
            rem_reg <= rem_next;
            dq_reg <= dq_next;
        end
    end

    assign quotient = dq_reg;
    assign status = '{busy: busy_reg, done: done_reg};

`ifndef SYNTH
    a_no_restart: assert property (@(posedge aclk) disable iff (!aresetn)
        busy_reg |-> !start)
        else $error("divider restarted while busy");
    a_done_after_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(done_reg) |-> $past(busy_reg))
        else $error("divider done without a run");
    a_busy_done_excl: assert property (@(posedge aclk) disable iff (!aresetn)
        !(busy_reg && done_reg))
        else $error("divider busy and done together");
`endif

endmodule
`default_nettype wire

[rtl/echo_median_bargraph_mapper_unit.sv]
// Echo median filter with distance-to-bar-graph mapping, top level.
//
// channel | dir | handshake         | content
// s_      | in  | s_tvalid/s_tready | s_tdata[14:0] echo_us
// m_      | out | m_tvalid/m_tready | m_tuser[0] dist_valid, m_tdata fields
// cfg_    | in  | cfg_wr_en         | cfg_index 0 near_limit_cm, 1 far_limit_cm
//
// From accept to result a beat passes these steps: the ring scan checks one
// candidate per cycle, a reciprocal multiply gives the distance, the 26-step
// divider forms the ratio, then the states ST_COLOR, ST_LIT1 and ST_LIT2 do the
// color and bar mapping and ST_DONE loads the output register. Without a ratio
// division the divider is skipped; with no valid sample the scan goes to ST_DONE.
// s_tready returns with the result, so a new beat is taken only once the last is through.
// Reset clears the ring, the pointer and the limits to 2 and 100 cm.
// A waiting result is held in the output register while the next beat is taken.
`default_nettype none
module echo_median_bargraph_mapper_unit #(
    parameter int WINDOW = 5,
    parameter int LED_COUNT = 9
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [15:0] s_tdata,   // [14:0] echo_us
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [39:0]      m_tdata,   // [13:0] distance_q4, [21:14] red_level,
                                        // [29:22] green_level, [33:30] lit_count
    output logic [0:0]       m_tuser,   // [0] dist_valid
    input  wire logic        cfg_wr_en,
    input  wire logic [0:0]  cfg_index,
    input  wire logic [8:0]  cfg_data
);

    localparam int PTR_W = $clog2(WINDOW);
    localparam int CNT_W = $clog2(WINDOW + 1);
    localparam int PROD_W = $clog2(100 * (LED_COUNT - 1) + 1);
    localparam int RP_W = PROD_W + 13;
    localparam int LIT_W = $clog2(LED_COUNT + 1);
    localparam int EW = emb_pkg::ECHO_W;

    emb_pkg::emb_state_t state_reg;

    logic [EW-1:0]             ring_reg [WINDOW];
    logic [PTR_W-1:0]          wptr_reg;
    logic [PTR_W-1:0]          cand_reg;
    logic [emb_pkg::LIM_W-1:0] near_reg;
    logic [emb_pkg::LIM_W-1:0] far_reg;
    logic [EW-1:0]             med_reg;
    logic                      start_reg;
    logic                      valid_reg;
    logic [emb_pkg::DIST_W-1:0] dq4_reg;
    logic [16:0]               ratio_reg;
    logic [7:0]                red_reg;
    logic [7:0]                green_reg;
    logic [6:0]                pct_reg;
    logic [PROD_W-1:0]         prod_reg;
    logic [LIT_W-1:0]          lit_reg;
    logic                      m_tvalid_reg;
    logic [39:0]               m_tdata_reg;
    logic [0:0]                m_tuser_reg;

    logic [EW-1:0]             echo_in;
    logic [CNT_W-1:0]          nz_cnt;
    logic [CNT_W-1:0]          lt_cnt;
    logic [CNT_W-1:0]          le_cnt;
    logic [CNT_W-1:0]          k_idx;
    logic [EW-1:0]             cand_val;
    logic                      hit;

    logic [emb_pkg::DIV_W-1:0] div_dividend;
    logic [emb_pkg::DEN_W-1:0] div_divisor;
    logic [emb_pkg::DIV_W-1:0] div_quo;
    emb_pkg::div_status_t      div_st;

    logic [EW+19:0]            dist_mul;
    logic [emb_pkg::DIST_W-1:0] q_dist;
    logic                      ratio_go;
    logic [12:0]               near16;
    logic [emb_pkg::DIST_W-1:0] dist_over;
    logic [24:0]               red_mul;
    logic [24:0]               green_mul;
    logic [23:0]               pct_mul;
    logic [RP_W-1:0]           recip_mul;
    logic [LIT_W-1:0]          lit_full;

    assign echo_in = (s_tdata[EW-1:0] > emb_pkg::ECHO_TIMEOUT_US) ? '0 : s_tdata[EW-1:0];

    always_comb begin
        nz_cnt = '0;
        lt_cnt = '0;
        le_cnt = '0;
        cand_val = ring_reg[cand_reg];
        for (int i = 0; i < WINDOW; i++) begin
            if (ring_reg[i] != '0) begin
                nz_cnt = nz_cnt + CNT_W'(1);
                if (ring_reg[i] < cand_val) lt_cnt = lt_cnt + CNT_W'(1);
                if (ring_reg[i] <= cand_val) le_cnt = le_cnt + CNT_W'(1);
            end
        end
        k_idx = nz_cnt >> 1;
        hit = (cand_val != '0) && (lt_cnt <= k_idx) && (k_idx < le_cnt);
    end

    assign near16 = {near_reg, 4'b0000};
    assign dist_mul = (EW+20)'(med_reg) * (EW+20)'(emb_pkg::RECIP_58);
    assign q_dist = dist_mul[emb_pkg::RECIP_58_SH +: emb_pkg::DIST_W];
    assign ratio_go = (state_reg == emb_pkg::ST_DIST) &&
                      !(far_reg <= near_reg || q_dist <= {1'b0, near16});
    assign dist_over = dq4_reg - {1'b0, near16};
    assign div_dividend = {dist_over, 12'b0};
    assign div_divisor = far_reg - near_reg;

    emb_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (start_reg),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .quotient (div_quo),
        .status   (div_st)
    );

    always_comb begin
        red_mul = 25'(emb_pkg::LEVEL_MAX) * (25'(emb_pkg::Q16_ONE) - 25'(ratio_reg));
        green_mul = 25'(emb_pkg::LEVEL_MAX) * 25'(ratio_reg);
        pct_mul = 24'(ratio_reg) * 24'd100;
        recip_mul = RP_W'(prod_reg) * RP_W'(emb_pkg::RECIP_100);
        lit_full = LIT_W'(recip_mul >> emb_pkg::RECIP_SH) + LIT_W'(1);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            near_reg <= 9'd2;
            far_reg <= 9'd100;
        end else if (cfg_wr_en) begin
            unique case (cfg_index[0])
                emb_pkg::REG_NEAR: near_reg <= cfg_data;
                emb_pkg::REG_FAR:  far_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= emb_pkg::ST_IDLE;
            wptr_reg <= '0;
            cand_reg <= '0;
            start_reg <= 1'b0;
            m_tvalid_reg <= 1'b0;
            for (int i = 0; i < WINDOW; i++) ring_reg[i] <= '0;
        end else begin
            start_reg <= ratio_go;
            if (m_tvalid_reg && m_tready && state_reg != emb_pkg::ST_DONE)
                m_tvalid_reg <= 1'b0;
            unique case (state_reg)
                emb_pkg::ST_IDLE: begin
                    if (s_tvalid) begin
                        ring_reg[wptr_reg] <= echo_in;
                        wptr_reg <= (wptr_reg == PTR_W'(WINDOW - 1)) ? '0 :
                                    wptr_reg + PTR_W'(1);
                        cand_reg <= '0;
                        state_reg <= emb_pkg::ST_SCAN;
                    end
                end
                emb_pkg::ST_SCAN: begin
                    if (nz_cnt == '0) begin
                        state_reg <= emb_pkg::ST_DONE;
                    end else if (hit) begin
                        state_reg <= emb_pkg::ST_DIST;
                    end else begin
                        cand_reg <= cand_reg + PTR_W'(1);
                    end
                end
                emb_pkg::ST_DIST: begin
                    if (ratio_go) begin
                        state_reg <= emb_pkg::ST_RDIV;
                    end else begin
                        state_reg <= emb_pkg::ST_COLOR;
                    end
                end
                emb_pkg::ST_RDIV: begin
                    if (div_st.done) state_reg <= emb_pkg::ST_COLOR;
                end
                emb_pkg::ST_COLOR: state_reg <= emb_pkg::ST_LIT1;
                emb_pkg::ST_LIT1:  state_reg <= emb_pkg::ST_LIT2;
                emb_pkg::ST_LIT2:  state_reg <= emb_pkg::ST_DONE;
                emb_pkg::ST_DONE: begin
                    if (!m_tvalid_reg || m_tready) begin
                        m_tvalid_reg <= 1'b1;
                        state_reg <= emb_pkg::ST_IDLE;
                    end
                end
                default: state_reg <= emb_pkg::ST_IDLE;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        unique case (state_reg)
            emb_pkg::ST_SCAN: begin
                valid_reg <= nz_cnt != '0;
                med_reg <= cand_val;
            end
            emb_pkg::ST_DIST: begin
                dq4_reg <= q_dist;
                if (far_reg <= near_reg) begin
                    ratio_reg <= (q_dist >= {1'b0, near16}) ? emb_pkg::Q16_ONE : '0;
                end else begin
                    ratio_reg <= '0;
                end
            end
            emb_pkg::ST_RDIV: begin
                if (div_st.done) begin
                    ratio_reg <= (div_quo > emb_pkg::DIV_W'(emb_pkg::Q16_ONE)) ?
                                 emb_pkg::Q16_ONE : div_quo[16:0];
                end
            end
            emb_pkg::ST_COLOR: begin
                if (ratio_reg < emb_pkg::Q16_HALF) begin
                    red_reg <= emb_pkg::LEVEL_MAX;
                    green_reg <= green_mul[22:15];
                end else begin
                    red_reg <= red_mul[22:15];
                    green_reg <= emb_pkg::LEVEL_MAX;
                end
                pct_reg <= pct_mul[22:16];
            end
            emb_pkg::ST_LIT1: prod_reg <= PROD_W'(32'(pct_reg) * 32'(LED_COUNT - 1));
            emb_pkg::ST_LIT2: lit_reg <= lit_full;
            emb_pkg::ST_DONE: begin
                if (!m_tvalid_reg || m_tready) begin
                    if (valid_reg) begin
                        m_tdata_reg <= {6'b0, 4'(lit_reg), green_reg, red_reg, dq4_reg};
                        m_tuser_reg <= 1'b1;
                    end else begin
                        m_tdata_reg <= '0;
                        m_tuser_reg <= 1'b0;
                    end
                end
            end
            default: ;
        endcase
    end

    assign s_tready = state_reg == emb_pkg::ST_IDLE;
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata = m_tdata_reg;
    assign m_tuser = m_tuser_reg;

`ifndef SYNTH
    a_one_at_a_time: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("beat accepted while previous beat in work");
    a_invalid_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tuser[0]) |-> (m_tdata == '0))
        else $error("invalid result carries nonzero fields");
    a_color_full: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser[0]) |-> (m_tdata[21:14] == 8'd255 || m_tdata[29:22] == 8'd255))
        else $error("bar color has no full channel");
    a_ptr_range: assert property (@(posedge aclk) disable iff (!aresetn)
        wptr_reg <= PTR_W'(WINDOW - 1))
        else $error("write pointer out of range");
    a_scan_hit: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == emb_pkg::ST_SCAN && nz_cnt != '0 && cand_reg == PTR_W'(WINDOW - 1))
        |-> hit)
        else $error("median not found in scan");
`endif

endmodule
`default_nettype wire
